// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    // Fixed field widths
    localparam int PRI_BITS    = 3;
    localparam int AGE_BITS    = 7;
    localparam int MODE_BITS   = 2;
    localparam int STATUS_BITS = 2;

    // Operation codes
    localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY_POP = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL_DROP = 2'd2;

    // Legal priority levels
    localparam logic [PRI_BITS-1:0] PRI_MIN = 3'd1;
    localparam logic [PRI_BITS-1:0] PRI_MAX = 3'd4;

    // Command broadcast to every cell for one transaction
    typedef struct packed {
        logic                ins;   // insert, queue not full
        logic                pop;   // pop, queue not empty
        logic                clr;   // clear all
        logic [PRI_BITS-1:0] lvl;   // clamped insert level
    } t_cmd;

endpackage

// ===== rtl/core/spq_in_if.sv =====
// Request channel: operation, level, age and tag.
interface spq_in_if #(
    parameter int TAG_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::MODE_BITS-1:0] mode;
    logic [spq_pkg::PRI_BITS-1:0]  priority_req;
    logic [spq_pkg::AGE_BITS-1:0]  age;
    logic [TAG_BITS-1:0]           tag;

    modport source (output valid, mode, priority_req, age, tag, input ready);
    modport sink   (input valid, mode, priority_req, age, tag, output ready);
endinterface

// ===== rtl/core/spq_out_if.sv =====
// Result channel: popped entry, status and occupancy.
interface spq_out_if #(
    parameter int TAG_BITS = 16,
    parameter int CNT_BITS = 5
);
    logic                            valid;
    logic                            ready;
    logic                            popped_valid;
    logic [spq_pkg::PRI_BITS-1:0]    popped_priority;
    logic [spq_pkg::AGE_BITS-1:0]    popped_age;
    logic [TAG_BITS-1:0]             popped_tag;
    logic [spq_pkg::STATUS_BITS-1:0] status;
    logic [CNT_BITS-1:0]             occupancy;

    modport source (output valid, popped_valid, popped_priority, popped_age, popped_tag,
                    status, occupancy, input ready);
    modport sink   (input valid, popped_valid, popped_priority, popped_age, popped_tag,
                    status, occupancy, output ready);
endinterface

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell array, count and result register.
//
//   channel  direction  payload                                   handshake
//   i_in     sink       mode, priority_req, age, tag              valid/ready
//   o_out    source     popped_valid/priority/age/tag, status,    valid/ready
//                       occupancy
//
// For each transaction every cell compares the new level
// in parallel and shifts or loads, and the result lands in the output register.
// One transaction per cycle is accepted while the output register is free or
// being taken. Reset (synchronous) empties the queue and the output register.
// A stalled result blocks further input until it is taken.
module sorted_priority_queue #(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    // Cell array contents
    logic                         w_valid [DEPTH];
    logic [spq_pkg::PRI_BITS-1:0] w_pri   [DEPTH];
    logic [spq_pkg::AGE_BITS-1:0] w_age   [DEPTH];
    logic [TAG_BITS-1:0]          w_tag   [DEPTH];
    logic                         w_yield [DEPTH];

    logic [CNT_BITS-1:0]             r_count, n_count;
    logic                            r_out_valid;
    logic                            r_pop_valid, n_pop_valid;
    logic [spq_pkg::PRI_BITS-1:0]    r_pop_pri, n_pop_pri;
    logic [spq_pkg::AGE_BITS-1:0]    r_pop_age, n_pop_age;
    logic [TAG_BITS-1:0]             r_pop_tag, n_pop_tag;
    logic [spq_pkg::STATUS_BITS-1:0] r_status, n_status;
    logic [CNT_BITS-1:0]             r_occ;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_empty;
    logic [spq_pkg::PRI_BITS-1:0] w_lvl;
    spq_pkg::t_cmd                w_cmd;

    // Handshake: accept when the result register is free or drains now
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_full  = (r_count == CNT_BITS'(DEPTH));
    assign w_empty = (r_count == '0);

    // Clamp the insert level into range
    always_comb begin
        if (i_in.priority_req < spq_pkg::PRI_MIN) begin
            w_lvl = spq_pkg::PRI_MIN;
        end else if (i_in.priority_req > spq_pkg::PRI_MAX) begin
            w_lvl = spq_pkg::PRI_MAX;
        end else begin
            w_lvl = i_in.priority_req;
        end
    end

    // Command decode
    always_comb begin
        w_cmd.ins = w_accept && (i_in.mode == spq_pkg::MODE_INSERT) && !w_full;
        w_cmd.pop = w_accept && (i_in.mode == spq_pkg::MODE_POP) && !w_empty;
        w_cmd.clr = w_accept && (i_in.mode == spq_pkg::MODE_CLEAR);
        w_cmd.lvl = w_lvl;
    end

    // Cell array, head at index 0
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                         l_valid, l_yield, r_nb_valid;
        logic [spq_pkg::PRI_BITS-1:0] l_pri, r_nb_pri;
        logic [spq_pkg::AGE_BITS-1:0] l_age, r_nb_age;
        logic [TAG_BITS-1:0]          l_tag, r_nb_tag;

        if (gi == 0) begin : g_head
            assign l_valid = 1'b0;
            assign l_pri   = '0;
            assign l_age   = '0;
            assign l_tag   = '0;
            assign l_yield = 1'b0;
        end else begin : g_body
            assign l_valid = w_valid[gi-1];
            assign l_pri   = w_pri[gi-1];
            assign l_age   = w_age[gi-1];
            assign l_tag   = w_tag[gi-1];
            assign l_yield = w_yield[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign r_nb_valid = 1'b0;
            assign r_nb_pri   = '0;
            assign r_nb_age   = '0;
            assign r_nb_tag   = '0;
        end else begin : g_inner
            assign r_nb_valid = w_valid[gi+1];
            assign r_nb_pri   = w_pri[gi+1];
            assign r_nb_age   = w_age[gi+1];
            assign r_nb_tag   = w_tag[gi+1];
        end

        spq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_age         (i_in.age),
            .i_tag         (i_in.tag),
            .i_left_valid  (l_valid),
            .i_left_pri    (l_pri),
            .i_left_age    (l_age),
            .i_left_tag    (l_tag),
            .i_left_yield  (l_yield),
            .i_right_valid (r_nb_valid),
            .i_right_pri   (r_nb_pri),
            .i_right_age   (r_nb_age),
            .i_right_tag   (r_nb_tag),
            .o_valid       (w_valid[gi]),
            .o_pri         (w_pri[gi]),
            .o_age         (w_age[gi]),
            .o_tag         (w_tag[gi]),
            .o_yield       (w_yield[gi])
        );
    end

    // Occupancy and result fields
    always_comb begin
        n_count     = r_count;
        n_pop_valid = 1'b0;
        n_pop_pri   = '0;
        n_pop_age   = '0;
        n_pop_tag   = '0;
        n_status    = spq_pkg::STATUS_OK;
        if (w_cmd.clr) begin
            n_count = '0;
        end else if (w_cmd.ins) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (w_cmd.pop) begin
            n_count     = r_count - CNT_BITS'(1);
            n_pop_valid = 1'b1;
            n_pop_pri   = w_pri[0];
            n_pop_age   = w_age[0];
            n_pop_tag   = w_tag[0];
        end else if (i_in.mode == spq_pkg::MODE_POP) begin
            n_status = spq_pkg::STATUS_EMPTY_POP;
        end else if (i_in.mode == spq_pkg::MODE_INSERT) begin
            n_status = spq_pkg::STATUS_FULL_DROP;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_valid <= n_pop_valid;
            r_pop_pri   <= n_pop_pri;
            r_pop_age   <= n_pop_age;
            r_pop_tag   <= n_pop_tag;
            r_status    <= n_status;
            r_occ       <= n_count;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.popped_valid    = r_pop_valid;
    assign o_out.popped_priority = r_pop_pri;
    assign o_out.popped_age      = r_pop_age;
    assign o_out.popped_tag      = r_pop_tag;
    assign o_out.status          = r_status;
    assign o_out.occupancy       = r_occ;

endmodule

// ===== rtl/core/spq_cell.sv =====
// One queue slot: holds an entry and shifts, loads or drops it by local decision.
module spq_cell #(
    parameter int TAG_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spq_pkg::t_cmd                i_cmd,
    input  logic [spq_pkg::AGE_BITS-1:0] i_age,
    input  logic [TAG_BITS-1:0]          i_tag,
    // neighbor toward the head
    input  logic                         i_left_valid,
    input  logic [spq_pkg::PRI_BITS-1:0] i_left_pri,
    input  logic [spq_pkg::AGE_BITS-1:0] i_left_age,
    input  logic [TAG_BITS-1:0]          i_left_tag,
    input  logic                         i_left_yield,
    // neighbor toward the tail
    input  logic                         i_right_valid,
    input  logic [spq_pkg::PRI_BITS-1:0] i_right_pri,
    input  logic [spq_pkg::AGE_BITS-1:0] i_right_age,
    input  logic [TAG_BITS-1:0]          i_right_tag,
    // own contents
    output logic                         o_valid,
    output logic [spq_pkg::PRI_BITS-1:0] o_pri,
    output logic [spq_pkg::AGE_BITS-1:0] o_age,
    output logic [TAG_BITS-1:0]          o_tag,
    output logic                         o_yield
);

    logic                         r_valid, n_valid;
    logic [spq_pkg::PRI_BITS-1:0] r_pri, n_pri;
    logic [spq_pkg::AGE_BITS-1:0] r_age, n_age;
    logic [TAG_BITS-1:0]          r_tag, n_tag;

    // Slot gives way to a new entry when empty or holding a worse level
    assign o_yield = !r_valid || (r_pri > i_cmd.lvl);

    // Next contents
    always_comb begin
        n_valid = r_valid;
        n_pri   = r_pri;
        n_age   = r_age;
        n_tag   = r_tag;
        if (i_cmd.clr) begin
            n_valid = 1'b0;
        end else if (i_cmd.pop) begin
            n_valid = i_right_valid;
            n_pri   = i_right_pri;
            n_age   = i_right_age;
            n_tag   = i_right_tag;
        end else if (i_cmd.ins && o_yield) begin
            if (i_left_yield) begin
                // insertion point lies further up: take the left entry
                n_valid = i_left_valid;
                n_pri   = i_left_pri;
                n_age   = i_left_age;
                n_tag   = i_left_tag;
            end else begin
                n_valid = 1'b1;
                n_pri   = i_cmd.lvl;
                n_age   = i_age;
                n_tag   = i_tag;
            end
        end
    end

    // Valid flag is control state; entry data is not reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_age <= n_age;
        r_tag <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_pri   = r_pri;
    assign o_age   = r_age;
    assign o_tag   = r_tag;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sorted priority queue: directed and random traffic.
module testbench;
    import spq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 16;
    localparam int CNT_BITS  = 5;
    localparam int N_ITEMS   = 1850;
    localparam int QUIET_END = 150;   // last transactions run with no idling
    localparam int HOLD_AT   = 400;   // sink starts its long hold-off here
    localparam int LONG_HOLD = 80;
    localparam int TAIL_CYC  = 8;
    localparam int WDOG_MAX  = 4000;

    // Mode 3 has no operation behind it
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic                 drain;  // hold back until all results are in
        logic [MODE_BITS-1:0] mode;
        logic [PRI_BITS-1:0]  lvl;
        logic [AGE_BITS-1:0]  age;
        logic [TAG_BITS-1:0]  tag;
    } pq_op_t;

    typedef struct packed {
        logic                   pv;
        logic [PRI_BITS-1:0]    ppri;
        logic [AGE_BITS-1:0]    page;
        logic [TAG_BITS-1:0]    ptag;
        logic [STATUS_BITS-1:0] st;
        logic [CNT_BITS-1:0]    occ;
    } pq_res_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    spq_in_if  #(.TAG_BITS(TAG_BITS))                     req_ch ();
    spq_out_if #(.TAG_BITS(TAG_BITS), .CNT_BITS(CNT_BITS)) rsp_ch ();

    sorted_priority_queue #(.DEPTH(DEPTH), .TAG_BITS(TAG_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (rsp_ch.source)
    );

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the queue contents
    logic [PRI_BITS-1:0] sh_lvl [DEPTH];
    logic [AGE_BITS-1:0] sh_age [DEPTH];
    logic [TAG_BITS-1:0] sh_tag [DEPTH];
    int sh_count;
    int n_ins, n_pop, n_full, n_empty, n_clr, n_nop;

    pq_op_t  pending_ops[$];
    pq_res_t want_results[$];
    pq_op_t  cur_op;
    pq_res_t got_res, exp_res;
    int      total_ops, gen_occ, kind;
    int      sent_cnt, rcv_cnt, in_gap, out_gap, err_cnt;
    int      hold_left, quiet_cycles;
    bit      hold_done;

    // Expected result of one transaction; updates the shadow queue
    function automatic pq_res_t predict_pq_result(pq_op_t op);
        pq_res_t             r;
        logic [PRI_BITS-1:0] lv;
        int                  pos, i;
        r = '0;
        case (op.mode)
            MODE_INSERT: begin
                lv = (op.lvl < PRI_MIN) ? PRI_MIN : ((op.lvl > PRI_MAX) ? PRI_MAX : op.lvl);
                if (sh_count >= DEPTH) begin
                    r.st = STATUS_FULL_DROP;
                    n_full++;
                end else begin
                    // new entry goes ahead of the first strictly worse level
                    pos = sh_count;
                    for (i = sh_count - 1; i >= 0; i--)
                        if (sh_lvl[i] > lv) pos = i;
                    for (i = sh_count; i > pos; i--) begin
                        sh_lvl[i] = sh_lvl[i-1];
                        sh_age[i] = sh_age[i-1];
                        sh_tag[i] = sh_tag[i-1];
                    end
                    sh_lvl[pos] = lv;
                    sh_age[pos] = op.age;
                    sh_tag[pos] = op.tag;
                    sh_count++;
                    n_ins++;
                end
            end
            MODE_POP: begin
                if (sh_count == 0) begin
                    r.st = STATUS_EMPTY_POP;
                    n_empty++;
                end else begin
                    r.pv   = 1'b1;
                    r.ppri = sh_lvl[0];
                    r.page = sh_age[0];
                    r.ptag = sh_tag[0];
                    for (i = 0; i + 1 < sh_count; i++) begin
                        sh_lvl[i] = sh_lvl[i+1];
                        sh_age[i] = sh_age[i+1];
                        sh_tag[i] = sh_tag[i+1];
                    end
                    sh_count--;
                    n_pop++;
                end
            end
            MODE_CLEAR: begin
                sh_count = 0;
                n_clr++;
            end
            default: n_nop++;
        endcase
        r.occ = sh_count[CNT_BITS-1:0];
        return r;
    endfunction

    // Append one transaction, tracking the occupancy it will leave
    function automatic void queue_op(logic [MODE_BITS-1:0] m, int lv, int ag, int tg,
                                     bit drain = 1'b0);
        pq_op_t op;
        op.drain = drain;
        op.mode  = m;
        op.lvl   = lv[PRI_BITS-1:0];
        op.age   = ag[AGE_BITS-1:0];
        op.tag   = tg[TAG_BITS-1:0];
        pending_ops.push_back(op);
        case (m)
            MODE_INSERT: if (gen_occ < DEPTH) gen_occ++;
            MODE_POP:    if (gen_occ > 0) gen_occ--;
            MODE_CLEAR:  gen_occ = 0;
            default:     ;
        endcase
    endfunction

    // Mostly legal levels and ages, now and then out of range
    function automatic void queue_rand_insert();
        int lv, ag;
        lv = $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0) lv = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 7);
        ag = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 110);
        queue_op(MODE_INSERT, lv, ag, $urandom);
    endfunction

    function automatic void queue_rand_pop();
        queue_op(MODE_POP, $urandom_range(0, 7), $urandom_range(0, 127), $urandom);
    endfunction

    // Random idling stops in every third stretch and near the end
    function automatic bit idle_on(int cnt);
        return (cnt < total_ops - QUIET_END) && ((cnt / 200) % 3 != 2);
    endfunction

    // Driver: offers pending transactions, predicts each one that is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                want_results.push_back(predict_pq_result(cur_op));
                sent_cnt <= sent_cnt + 1;
            end
            if (req_ch.valid && !req_ch.ready) begin
                // transaction still on offer
            end else if (in_gap > 0) begin
                in_gap--;
                req_ch.valid <= 1'b0;
            end else if (pending_ops.size() == 0 ||
                         (pending_ops[0].drain &&
                          rcv_cnt != sent_cnt + (req_ch.valid ? 1 : 0))) begin
                req_ch.valid <= 1'b0;
            end else if (idle_on(sent_cnt) && hold_left == 0 &&
                         $urandom_range(0, 5) == 0) begin
                in_gap = $urandom_range(1, 14) - 1;
                req_ch.valid <= 1'b0;
            end else begin
                cur_op = pending_ops.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.mode         <= cur_op.mode;
                req_ch.priority_req <= cur_op.lvl;
                req_ch.age          <= cur_op.age;
                req_ch.tag          <= cur_op.tag;
            end
        end
    end

    // One long hold-off of the result sink while the driver keeps offering
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each result against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got_res = '{rsp_ch.popped_valid, rsp_ch.popped_priority, rsp_ch.popped_age,
                            rsp_ch.popped_tag, rsp_ch.status, rsp_ch.occupancy};
                if (want_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: result with nothing outstanding: %p", got_res);
                end else begin
                    exp_res = want_results.pop_front();
                    if (got_res.pv !== exp_res.pv || got_res.ppri !== exp_res.ppri ||
                        got_res.page !== exp_res.page || got_res.ptag !== exp_res.ptag ||
                        got_res.st !== exp_res.st || got_res.occ !== exp_res.occ) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("ERROR: result %0d expected %p", rcv_cnt, exp_res);
                            $display("       actual            %p", got_res);
                        end
                    end
                end
                rcv_cnt <= rcv_cnt + 1;
            end
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                rsp_ch.ready <= 1'b0;
            end else if (idle_on(rcv_cnt) && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(1, 14) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("Timeout: no transaction for %0d cycles", WDOG_MAX);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_INSERT;
        req_ch.priority_req = '0;
        req_ch.age          = '0;
        req_ch.tag          = '0;
        rsp_ch.ready        = 1'b0;

        // Directed: empty pop, unused mode, level clamps, field extremes, clear
        queue_op(MODE_POP, 7, 127, 16'hFFFF);
        queue_op(MODE_UNUSED, 5, 99, 16'h5A5A);
        queue_op(MODE_INSERT, 4, 110, 16'hFFFF);
        queue_op(MODE_INSERT, 1, 1, 16'h0000);
        queue_op(MODE_INSERT, 0, 0, 16'h1234);
        queue_op(MODE_INSERT, 7, 127, 16'h8001);
        queue_op(MODE_INSERT, 2, 55, 16'hAAAA);
        queue_op(MODE_INSERT, 3, 64, 16'h5555);
        queue_op(MODE_INSERT, 5, 2, 16'h7FFF);
        queue_op(MODE_INSERT, 6, 3, 16'h0001);
        queue_op(MODE_INSERT, 1, 9, 16'hC3C3);
        repeat (4) queue_rand_pop();
        queue_op(MODE_CLEAR, 0, 0, 16'h0000);
        queue_op(MODE_POP, 0, 0, 16'h0000);
        queue_op(MODE_INSERT, 2, 42, 16'hBEEF);

        // Fill past full first, after a pause for the directed results
        queue_rand_insert();
        pending_ops[pending_ops.size()-1].drain = 1'b1;
        while (gen_occ < DEPTH) queue_rand_insert();
        repeat (2) queue_rand_insert();

        // Random bursts of inserts and pops, fills, drains, clears and noise
        while (pending_ops.size() < N_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                repeat ($urandom_range(1, 20)) queue_rand_insert();
            end else if (kind < 72) begin
                repeat ($urandom_range(1, 20)) queue_rand_pop();
            end else if (kind < 82) begin
                while (gen_occ < DEPTH) queue_rand_insert();
                repeat ($urandom_range(1, 3)) queue_rand_insert();
            end else if (kind < 92) begin
                while (gen_occ > 0) queue_rand_pop();
                queue_rand_pop();
            end else if (kind < 97) begin
                queue_op(MODE_CLEAR, $urandom_range(0, 7), $urandom_range(0, 127), $urandom);
            end else begin
                queue_op(MODE_UNUSED, $urandom_range(0, 7), $urandom_range(0, 127), $urandom);
            end
        end
        pending_ops[900].drain  = 1'b1;
        pending_ops[1400].drain = 1'b1;
        total_ops = pending_ops.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || req_ch.valid || want_results.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYC) @(negedge i_clk);

        $display("Covered %0d transactions: %0d inserts, %0d pops, %0d clears, %0d no-ops",
                 total_ops, n_ins, n_pop, n_clr, n_nop);
        $display("Dropped on full: %0d, pops on empty: %0d", n_full, n_empty);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sorted_priority_queue.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_in_if.sv
rtl/core/spq_out_if.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
tb/sv/testbench.sv
